@@ design/lcdwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Character LCD write controller package
// Shared types and constants for the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package lcdwc_pkg;

  localparam int COL_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int NUM_W   = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CONV_W  = 5;
  localparam int DCNT_W  = 4;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CMD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR     = 2'd3;

  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_GOTO,
    S_CLR,
    S_HOME,
    S_PUT,
    S_CONV,
    S_SKIP,
    S_MINUS,
    S_DIGIT
  } state_t;

  typedef enum logic [2:0] {
    SEL_INPUT,
    SEL_TARGET,
    SEL_CLEAR,
    SEL_HOME,
    SEL_WRAP,
    SEL_MINUS,
    SEL_DIGIT
  } byte_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_TARGET,
    CUR_HOME,
    CUR_WRAP,
    CUR_ADVANCE
  } cursor_op_t;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       rs;
    byte_sel_t  sel;
    logic       last;
    cursor_op_t cur_op;
    logic       conv_step;
    logic       digit_shift;
  } ctrl_cmd_t;

  typedef struct packed {
    logic byte_free;
    logic wrap_needed;
    logic conv_last;
    logic top_zero;
    logic digit_one;
    logic negative;
  } dp_status_t;

endpackage

@@ design/lcdwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Character LCD write controller sequencer
// Walks each item through its command and data bytes and steers the datapath.
// ----------------------------------------------------------------------------
module lcdwc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic [lcdwc_pkg::KIND_W-1:0]      kind,
  input  lcdwc_pkg::dp_status_t             status,
  output logic                              item_stall,
  output lcdwc_pkg::ctrl_cmd_t              cmd
);

  lcdwc_pkg::state_t state;
  lcdwc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdwc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != lcdwc_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      lcdwc_pkg::S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          unique case (kind)
            lcdwc_pkg::KIND_CHAR:   state_next = lcdwc_pkg::S_PUT;
            lcdwc_pkg::KIND_CMD:    state_next = lcdwc_pkg::S_CMD;
            lcdwc_pkg::KIND_GOTO:   state_next = lcdwc_pkg::S_GOTO;
            lcdwc_pkg::KIND_CLEAR:  state_next = lcdwc_pkg::S_CLR;
            lcdwc_pkg::KIND_NUMBER: state_next = lcdwc_pkg::S_CONV;
            default:                state_next = lcdwc_pkg::S_IDLE;
          endcase
        end
      end
      lcdwc_pkg::S_CMD: begin
        if (status.byte_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = lcdwc_pkg::SEL_INPUT;
          cmd.last   = 1'b1;
          state_next = lcdwc_pkg::S_IDLE;
        end
      end
      lcdwc_pkg::S_GOTO: begin
        if (status.byte_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = lcdwc_pkg::SEL_TARGET;
          cmd.last   = 1'b1;
          cmd.cur_op = lcdwc_pkg::CUR_TARGET;
          state_next = lcdwc_pkg::S_IDLE;
        end
      end
      lcdwc_pkg::S_CLR: begin
        if (status.byte_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = lcdwc_pkg::SEL_CLEAR;
          state_next = lcdwc_pkg::S_HOME;
        end
      end
      lcdwc_pkg::S_HOME: begin
        if (status.byte_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = lcdwc_pkg::SEL_HOME;
          cmd.last   = 1'b1;
          cmd.cur_op = lcdwc_pkg::CUR_HOME;
          state_next = lcdwc_pkg::S_IDLE;
        end
      end
      lcdwc_pkg::S_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) begin
          state_next = lcdwc_pkg::S_SKIP;
        end
      end
      lcdwc_pkg::S_SKIP: begin
        if (status.top_zero && !status.digit_one) begin
          cmd.digit_shift = 1'b1;
        end else if (status.negative) begin
          state_next = lcdwc_pkg::S_MINUS;
        end else begin
          state_next = lcdwc_pkg::S_DIGIT;
        end
      end
      lcdwc_pkg::S_PUT, lcdwc_pkg::S_MINUS, lcdwc_pkg::S_DIGIT: begin
        if (status.byte_free) begin
          cmd.push = 1'b1;
          if (status.wrap_needed) begin
            cmd.sel    = lcdwc_pkg::SEL_WRAP;
            cmd.cur_op = lcdwc_pkg::CUR_WRAP;
          end else begin
            cmd.rs     = 1'b1;
            cmd.cur_op = lcdwc_pkg::CUR_ADVANCE;
            priority case (state)
              lcdwc_pkg::S_PUT: begin
                cmd.sel    = lcdwc_pkg::SEL_INPUT;
                cmd.last   = 1'b1;
                state_next = lcdwc_pkg::S_IDLE;
              end
              lcdwc_pkg::S_MINUS: begin
                cmd.sel    = lcdwc_pkg::SEL_MINUS;
                state_next = lcdwc_pkg::S_DIGIT;
              end
              default: begin
                cmd.sel         = lcdwc_pkg::SEL_DIGIT;
                cmd.last        = status.digit_one;
                cmd.digit_shift = 1'b1;
                if (status.digit_one) begin
                  state_next = lcdwc_pkg::S_IDLE;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_next = lcdwc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/lcdwc_dpath.sv @@
// ----------------------------------------------------------------------------
// Character LCD write controller datapath
// Holds configuration, the cursor, the decimal converter and the bus sender.
// ----------------------------------------------------------------------------
module lcdwc_dpath #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lcdwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcdwc_pkg::BYTE_W-1:0]          cfg_data,
  input  logic [lcdwc_pkg::BYTE_W-1:0]          byte_value,
  input  logic                                  target_row,
  input  logic [lcdwc_pkg::COL_W-1:0]           target_col,
  input  logic signed [lcdwc_pkg::NUM_W-1:0]    number,
  input  lcdwc_pkg::ctrl_cmd_t                  cmd,
  output lcdwc_pkg::dp_status_t                 status,
  output logic                                  strobe_valid,
  input  logic                                  strobe_stall,
  output logic                                  reg_select,
  output logic [lcdwc_pkg::BYTE_W-1:0]          bus_value,
  output logic                                  last
);

  logic                                four_bit_mode;
  logic [lcdwc_pkg::BYTE_W-1:0]        row0_base;
  logic [lcdwc_pkg::BYTE_W-1:0]        row1_base;
  logic [lcdwc_pkg::BYTE_W-1:0]        clear_code;

  logic [lcdwc_pkg::COL_W-1:0]         cursor_col;
  logic                                cursor_row;

  logic [lcdwc_pkg::BYTE_W-1:0]        item_byte;
  logic                                item_row;
  logic [lcdwc_pkg::COL_W-1:0]         item_col;
  logic                                negative;
  logic [lcdwc_pkg::NUM_W-1:0]         mag;
  logic [lcdwc_pkg::BCD_W-1:0]         bcd;
  logic [lcdwc_pkg::BCD_W-1:0]         bcd_adj;
  logic [lcdwc_pkg::CONV_W-1:0]        conv_cnt;
  logic [lcdwc_pkg::DCNT_W-1:0]        digit_cnt;

  logic                                pend;
  logic                                pend_hi;
  logic                                pend_rs;
  logic                                pend_last;
  logic [lcdwc_pkg::BYTE_W-1:0]        pend_byte;

  logic [1:0]                          row_inc;
  logic                                wrap_row;
  logic [lcdwc_pkg::BYTE_W-1:0]        target_base;
  logic [lcdwc_pkg::BYTE_W-1:0]        wrap_base;
  logic [lcdwc_pkg::BYTE_W-1:0]        push_byte;
  logic                                out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b1;
      row0_base     <= 8'd128;
      row1_base     <= 8'd192;
      clear_code    <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcdwc_pkg::CFG_FOUR_BIT:  four_bit_mode <= cfg_data[0];
        lcdwc_pkg::CFG_ROW0_BASE: row0_base     <= cfg_data;
        lcdwc_pkg::CFG_ROW1_BASE: row1_base     <= cfg_data;
        lcdwc_pkg::CFG_CLEAR:     clear_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign row_inc     = {1'b0, cursor_row} + 2'd1;
  assign wrap_row    = (row_inc >= 2'(ROWS)) ? 1'b0 : row_inc[0];
  assign target_base = item_row ? row1_base : row0_base;
  assign wrap_base   = wrap_row ? row1_base : row0_base;

  always_comb begin
    unique case (cmd.sel)
      lcdwc_pkg::SEL_INPUT:  push_byte = item_byte;
      lcdwc_pkg::SEL_TARGET: push_byte = target_base + {2'b00, item_col};
      lcdwc_pkg::SEL_CLEAR:  push_byte = clear_code;
      lcdwc_pkg::SEL_HOME:   push_byte = row0_base;
      lcdwc_pkg::SEL_WRAP:   push_byte = wrap_base;
      lcdwc_pkg::SEL_MINUS:  push_byte = lcdwc_pkg::ASCII_MINUS;
      lcdwc_pkg::SEL_DIGIT:  push_byte = lcdwc_pkg::ASCII_ZERO
                                         + {4'b0000, bcd[lcdwc_pkg::BCD_W-1 -: 4]};
      default:               push_byte = item_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= 1'b0;
    end else begin
      unique case (cmd.cur_op)
        lcdwc_pkg::CUR_TARGET: begin
          cursor_col <= item_col;
          cursor_row <= item_row;
        end
        lcdwc_pkg::CUR_HOME: begin
          cursor_col <= '0;
          cursor_row <= 1'b0;
        end
        lcdwc_pkg::CUR_WRAP: begin
          cursor_col <= '0;
          cursor_row <= wrap_row;
        end
        lcdwc_pkg::CUR_ADVANCE: cursor_col <= cursor_col + 6'd1;
        default: ;
      endcase
    end
  end

  // Shift-and-add-3 binary to BCD conversion, one bit per cycle.
  always_comb begin
    for (int d = 0; d < lcdwc_pkg::DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_byte <= byte_value;
      item_row  <= target_row;
      item_col  <= target_col;
      negative  <= number[lcdwc_pkg::NUM_W-1];
      mag       <= number[lcdwc_pkg::NUM_W-1] ? (32'd0 - $unsigned(number))
                                              : $unsigned(number);
      bcd       <= '0;
      conv_cnt  <= '0;
      digit_cnt <= lcdwc_pkg::DCNT_W'(lcdwc_pkg::DIGITS);
    end else if (cmd.conv_step) begin
      {bcd, mag} <= {bcd_adj[lcdwc_pkg::BCD_W-2:0], mag, 1'b0};
      conv_cnt   <= conv_cnt + 5'd1;
    end else if (cmd.digit_shift) begin
      bcd       <= {bcd[lcdwc_pkg::BCD_W-5:0], 4'b0000};
      digit_cnt <= digit_cnt - 4'd1;
    end
  end

  assign out_free = !strobe_valid || !strobe_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      strobe_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        pend <= 1'b1;
      end else if (out_free && pend && !(four_bit_mode && pend_hi)) begin
        pend <= 1'b0;
      end
      if (out_free) begin
        strobe_valid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_hi   <= 1'b1;
      pend_rs   <= cmd.rs;
      pend_last <= cmd.last;
      pend_byte <= push_byte;
    end else if (out_free && pend) begin
      pend_hi <= 1'b0;
    end
    if (out_free && pend) begin
      reg_select <= pend_rs;
      if (!four_bit_mode) begin
        bus_value <= pend_byte;
        last      <= pend_last;
      end else if (pend_hi) begin
        bus_value <= {4'b0000, pend_byte[7:4]};
        last      <= 1'b0;
      end else begin
        bus_value <= {4'b0000, pend_byte[3:0]};
        last      <= pend_last;
      end
    end
  end

  assign status.byte_free   = !pend;
  assign status.wrap_needed = (cursor_col >= lcdwc_pkg::COL_W'(COLUMNS));
  assign status.conv_last   = (conv_cnt == 5'd31);
  assign status.top_zero    = (bcd[lcdwc_pkg::BCD_W-1 -: 4] == 4'd0);
  assign status.digit_one   = (digit_cnt == 4'd1);
  assign status.negative    = negative;

endmodule

@@ design/char_lcd_write_controller.sv @@
// An item is taken when the block is idle. The strobe sender holds one byte at a time and
// takes the next one only after the last strobe of the current one is registered at the
// output. A byte goes out as one strobe in 8-bit mode and as a high and a low nibble
// strobe in 4-bit mode, back to back when there are no stalls. An item holds the input
// longer in 4-bit mode, when a wrap goto goes first, or when the sender still holds the
// previous item's byte. A number first runs a shift-and-add-3 decimal conversion of its
// 32-bit magnitude, then drops leading zeros, then sends its sign and digit bytes with any
// wrap gotos through the same sender. The next item is taken once the last byte is handed
// to the sender, while that byte's strobes may still be waiting at the output.
// ----------------------------------------------------------------------------
// Character LCD write controller
// Turns characters, commands, gotos, clears and numbers into LCD bus strobes.
// ----------------------------------------------------------------------------
module char_lcd_write_controller #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lcdwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcdwc_pkg::BYTE_W-1:0]          cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [lcdwc_pkg::KIND_W-1:0]          kind,
  input  logic [lcdwc_pkg::BYTE_W-1:0]          byte_value,
  input  logic                                  target_row,
  input  logic [lcdwc_pkg::COL_W-1:0]           target_col,
  input  logic signed [lcdwc_pkg::NUM_W-1:0]    number,
  output logic                                  strobe_valid,
  input  logic                                  strobe_stall,
  output logic                                  reg_select,
  output logic [lcdwc_pkg::BYTE_W-1:0]          bus_value,
  output logic                                  last
);

  lcdwc_pkg::ctrl_cmd_t  cmd;
  lcdwc_pkg::dp_status_t status;

  lcdwc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  lcdwc_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_value   (byte_value),
    .target_row   (target_row),
    .target_col   (target_col),
    .number       (number),
    .cmd          (cmd),
    .status       (status),
    .strobe_valid (strobe_valid),
    .strobe_stall (strobe_stall),
    .reg_select   (reg_select),
    .bus_value    (bus_value),
    .last         (last)
  );

endmodule

@@ sim/lcd_strobe_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD strobe checker
// Watches the register, item and strobe ports of the write controller. It
// keeps its own cursor and register copies, works out the bus strobes of
// every accepted item and compares each strobe beat with the oldest one due.
// ----------------------------------------------------------------------------
module lcd_strobe_checker #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lcdwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcdwc_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                                item_valid,
  input  logic                                item_stall,
  input  logic [lcdwc_pkg::KIND_W-1:0]        kind,
  input  logic [lcdwc_pkg::BYTE_W-1:0]        byte_value,
  input  logic                                target_row,
  input  logic [lcdwc_pkg::COL_W-1:0]         target_col,
  input  logic signed [lcdwc_pkg::NUM_W-1:0]  number,
  input  logic                                strobe_valid,
  input  logic                                strobe_stall,
  input  logic                                reg_select,
  input  logic [lcdwc_pkg::BYTE_W-1:0]        bus_value,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  strobes_checked
);

  typedef struct packed {
    logic                         rs;
    logic [lcdwc_pkg::BYTE_W-1:0] bus;
    logic                         last_beat;
  } strobe_t;

  strobe_t                      due_strobes[$];
  strobe_t                      want;
  strobe_t                      seen;
  logic                         nibble_mode;
  logic [lcdwc_pkg::BYTE_W-1:0] base_row0;
  logic [lcdwc_pkg::BYTE_W-1:0] base_row1;
  logic [lcdwc_pkg::BYTE_W-1:0] clear_cmd;
  logic [lcdwc_pkg::COL_W-1:0]  cur_col;
  logic                         cur_row;
  int                           mismatches = 0;
  int                           checked = 0;

  function automatic void queue_byte(logic rs, logic [lcdwc_pkg::BYTE_W-1:0] value);
    if (nibble_mode) begin
      due_strobes.push_back('{rs, {4'h0, value[7:4]}, 1'b0});
      due_strobes.push_back('{rs, {4'h0, value[3:0]}, 1'b0});
    end else begin
      due_strobes.push_back('{rs, value, 1'b0});
    end
  endfunction

  function automatic void move_cursor(logic row, logic [lcdwc_pkg::COL_W-1:0] col);
    logic [lcdwc_pkg::BYTE_W-1:0] base;
    base = row ? base_row1 : base_row0;
    queue_byte(1'b0, base + lcdwc_pkg::BYTE_W'(col));
    cur_col = col;
    cur_row = row;
  endfunction

  function automatic void put_char(logic [lcdwc_pkg::BYTE_W-1:0] ch);
    int next_row;
    if (cur_col >= COLUMNS) begin
      next_row = cur_row + 1;
      if (next_row >= ROWS) begin
        next_row = 0;
      end
      move_cursor(next_row[0], '0);
    end
    queue_byte(1'b1, ch);
    cur_col = cur_col + 1'b1;
  endfunction

  function automatic void print_number(logic [lcdwc_pkg::NUM_W-1:0] value);
    logic [lcdwc_pkg::NUM_W-1:0]  mag;
    logic [lcdwc_pkg::BYTE_W-1:0] digit_chars[lcdwc_pkg::DIGITS];
    int                           n;
    mag = value;
    n = 0;
    if (value[lcdwc_pkg::NUM_W-1]) begin
      mag = ~value + 1'b1;
      put_char(lcdwc_pkg::ASCII_MINUS);
    end
    do begin
      digit_chars[n] = lcdwc_pkg::ASCII_ZERO + lcdwc_pkg::BYTE_W'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < lcdwc_pkg::DIGITS);
    while (n > 0) begin
      n--;
      put_char(digit_chars[n]);
    end
  endfunction

  function automatic void predict_item(logic [lcdwc_pkg::KIND_W-1:0] k,
                                       logic [lcdwc_pkg::BYTE_W-1:0] b,
                                       logic row, logic [lcdwc_pkg::COL_W-1:0] col,
                                       logic [lcdwc_pkg::NUM_W-1:0] value);
    int      queued_before;
    strobe_t final_beat;
    queued_before = due_strobes.size();
    case (k)
      lcdwc_pkg::KIND_CHAR: put_char(b);
      lcdwc_pkg::KIND_CMD: queue_byte(1'b0, b);
      lcdwc_pkg::KIND_GOTO: move_cursor(row, col);
      lcdwc_pkg::KIND_CLEAR: begin
        queue_byte(1'b0, clear_cmd);
        move_cursor(1'b0, '0);
      end
      lcdwc_pkg::KIND_NUMBER: print_number(value);
      default: ;
    endcase
    if (due_strobes.size() > queued_before) begin
      final_beat = due_strobes.pop_back();
      final_beat.last_beat = 1'b1;
      due_strobes.push_back(final_beat);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] strobe %0d: %s", $time, checked, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_strobes.delete();
      nibble_mode = 1'b1;
      base_row0 = 8'd128;
      base_row1 = 8'd192;
      clear_cmd = 8'd1;
      cur_col = '0;
      cur_row = 1'b0;
    end else begin
      if (strobe_valid && !strobe_stall) begin
        seen = '{reg_select, bus_value, last};
        if (due_strobes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat rs=%0b bus=%02h last=%0b",
                                    seen.rs, seen.bus, seen.last_beat));
        end else begin
          want = due_strobes.pop_front();
          if (seen.rs !== want.rs) begin
            report_mismatch($sformatf("reg_select expected %0b got %0b", want.rs, seen.rs));
          end
          if (seen.bus !== want.bus) begin
            report_mismatch($sformatf("bus_value expected %02h got %02h", want.bus, seen.bus));
          end
          if (seen.last_beat !== want.last_beat) begin
            report_mismatch($sformatf("last expected %0b got %0b",
                                      want.last_beat, seen.last_beat));
          end
        end
        checked++;
      end
      if (item_valid && !item_stall) begin
        predict_item(kind, byte_value, target_row, target_col, number);
      end
      if (cfg_write) begin
        case (cfg_index)
          lcdwc_pkg::CFG_FOUR_BIT: nibble_mode = cfg_data[0];
          lcdwc_pkg::CFG_ROW0_BASE: base_row0 = cfg_data;
          lcdwc_pkg::CFG_ROW1_BASE: base_row1 = cfg_data;
          lcdwc_pkg::CFG_CLEAR: clear_cmd = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= due_strobes.size();
    fail_count <= mismatches;
    strobes_checked <= checked;
  end

endmodule

@@ sim/char_lcd_write_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD write controller testbench
// Feeds characters, commands, gotos, clears and numbers through the
// controller under several register settings, with random gaps on the item
// side and random stalls on the strobe side. A checker module predicts and
// compares every strobe; this module drives the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module char_lcd_write_controller_tb;

  localparam int COLUMNS       = 16;
  localparam int ROWS          = 2;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_ITEMS   = 77;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [lcdwc_pkg::CFG_IDX_W-1:0]    cfg_index = lcdwc_pkg::CFG_FOUR_BIT;
  logic [lcdwc_pkg::BYTE_W-1:0]       cfg_data = '0;
  logic                               item_valid = 1'b0;
  logic                               item_stall;
  logic [lcdwc_pkg::KIND_W-1:0]       kind = lcdwc_pkg::KIND_CHAR;
  logic [lcdwc_pkg::BYTE_W-1:0]       byte_value = '0;
  logic                               target_row = 1'b0;
  logic [lcdwc_pkg::COL_W-1:0]        target_col = '0;
  logic signed [lcdwc_pkg::NUM_W-1:0] number = '0;
  logic                               strobe_valid;
  logic                               strobe_stall = 1'b0;
  logic                               reg_select;
  logic [lcdwc_pkg::BYTE_W-1:0]       bus_value;
  logic                               last;

  logic                               calm = 1'b0;
  int                                 stall_left = 0;
  int                                 stall_draw;
  int                                 cycle_count = 0;
  int                                 items_sent = 0;
  int                                 numbers_sent = 0;
  int                                 chars_sent = 0;
  int                                 settings_applied = 0;
  int                                 fail_count;
  int                                 pending;
  int                                 strobes_checked;

  always #1 clk = ~clk;

  char_lcd_write_controller #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .byte_value  (byte_value),
    .target_row  (target_row),
    .target_col  (target_col),
    .number      (number),
    .strobe_valid(strobe_valid),
    .strobe_stall(strobe_stall),
    .reg_select  (reg_select),
    .bus_value   (bus_value),
    .last        (last)
  );

  lcd_strobe_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .kind           (kind),
    .byte_value     (byte_value),
    .target_row     (target_row),
    .target_col     (target_col),
    .number         (number),
    .strobe_valid   (strobe_valid),
    .strobe_stall   (strobe_stall),
    .reg_select     (reg_select),
    .bus_value      (bus_value),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending),
    .strobes_checked(strobes_checked)
  );

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst || calm) begin
      strobe_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      strobe_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_draw = draw_gap();
      strobe_stall <= (stall_draw > 0);
      stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d strobes still due", cycle_count, pending);
      $display("char_lcd_write_controller_tb failed");
      $finish;
    end
  end

  task automatic send_item(logic [lcdwc_pkg::KIND_W-1:0] k, logic [lcdwc_pkg::BYTE_W-1:0] b,
                           logic row, logic [lcdwc_pkg::COL_W-1:0] col,
                           logic [lcdwc_pkg::NUM_W-1:0] value);
    int gap;
    calm <= ((items_sent / 37) % 4 == 3);
    gap = ((items_sent / 37) % 4 == 3) ? 0 : draw_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    byte_value <= b;
    target_row <= row;
    target_col <= col;
    number <= value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (k == lcdwc_pkg::KIND_NUMBER) numbers_sent++;
    if (k == lcdwc_pkg::KIND_CHAR) chars_sent++;
  endtask

  task automatic random_item(output bit counted);
    int                           pick;
    int unsigned                  scale;
    logic [lcdwc_pkg::KIND_W-1:0] k;
    logic [lcdwc_pkg::COL_W-1:0]  col;
    logic [lcdwc_pkg::NUM_W-1:0]  value;
    pick = $urandom_range(0, 99);
    if (pick < 45) k = lcdwc_pkg::KIND_CHAR;
    else if (pick < 67) k = lcdwc_pkg::KIND_NUMBER;
    else if (pick < 80) k = lcdwc_pkg::KIND_GOTO;
    else if (pick < 89) k = lcdwc_pkg::KIND_CMD;
    else if (pick < 96) k = lcdwc_pkg::KIND_CLEAR;
    else k = lcdwc_pkg::KIND_NUMBER + lcdwc_pkg::KIND_W'($urandom_range(1, 3));
    col = ($urandom_range(0, 4) == 0) ? lcdwc_pkg::COL_W'($urandom)
                                      : lcdwc_pkg::COL_W'($urandom_range(0, 39));
    case ($urandom_range(0, 4))
      0: value = $urandom_range(0, 99);
      1: value = $urandom;
      2: value = $urandom_range(0, 99999);
      3: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'hFFFF_FFFF;
          default: value = '0;
        endcase
      end
      default: begin
        scale = 1;
        repeat ($urandom_range(0, 9)) scale = scale * 10;
        value = scale - $urandom_range(0, 1);
      end
    endcase
    if ($urandom_range(0, 2) == 0) value = ~value + 1'b1;
    send_item(k, lcdwc_pkg::BYTE_W'($urandom), 1'($urandom), col, value);
    counted = (k <= lcdwc_pkg::KIND_NUMBER);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic nibble, logic [lcdwc_pkg::BYTE_W-1:0] base0,
                               logic [lcdwc_pkg::BYTE_W-1:0] base1,
                               logic [lcdwc_pkg::BYTE_W-1:0] clr);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= lcdwc_pkg::CFG_FOUR_BIT;
    cfg_data <= {{(lcdwc_pkg::BYTE_W-1){1'b0}}, nibble};
    @(posedge clk);
    cfg_index <= lcdwc_pkg::CFG_ROW0_BASE;
    cfg_data <= base0;
    @(posedge clk);
    cfg_index <= lcdwc_pkg::CFG_ROW1_BASE;
    cfg_data <= base1;
    @(posedge clk);
    cfg_index <= lcdwc_pkg::CFG_CLEAR;
    cfg_data <= clr;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_phase();
    int counted_items;
    bit counted;
    counted_items = 0;
    while (counted_items < PHASE_ITEMS) begin
      random_item(counted);
      if (counted) counted_items++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(lcdwc_pkg::KIND_CHAR, 8'h00, 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_CHAR, 8'hFF, 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_CMD, 8'h00, 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_CMD, 8'hFF, 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b1, 6'd39, '0);
    send_item(lcdwc_pkg::KIND_CHAR, "A", 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b0, 6'd63, '0);
    send_item(lcdwc_pkg::KIND_CHAR, "B", 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b0, 6'd16, '0);
    send_item(lcdwc_pkg::KIND_CHAR, "Z", 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_CLEAR, 8'h00, 1'b0, '0, '0);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, 32'd0);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, 32'h7FFF_FFFF);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, 32'h8000_0000);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, 32'hFFFF_FFFF);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, -32'sd10);
    send_item(lcdwc_pkg::KIND_NUMBER + 3'd1, 8'hA5, 1'b1, 6'd5, 32'd7);
    send_item(lcdwc_pkg::KIND_NUMBER + 3'd2, 8'h5A, 1'b0, 6'd9, 32'd8);
    send_item(lcdwc_pkg::KIND_NUMBER + 3'd3, 8'hFF, 1'b1, 6'd63, 32'd9);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b0, 6'd15, '0);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, 32'd12345);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b1, 6'd14, '0);
    send_item(lcdwc_pkg::KIND_NUMBER, 8'h00, 1'b0, '0, -32'sd7);
    send_item(lcdwc_pkg::KIND_GOTO, 8'h00, 1'b1, 6'd0, '0);
    drain();

    apply_setting(1'b0, 8'h00, 8'hFF, 8'h00);
    random_phase();
    drain();
    apply_setting(1'b1, 8'hFF, 8'h00, 8'hFF);
    random_phase();
    drain();
    apply_setting(1'b0, lcdwc_pkg::BYTE_W'($urandom), lcdwc_pkg::BYTE_W'($urandom),
                  lcdwc_pkg::BYTE_W'($urandom));
    random_phase();
    drain();
    apply_setting(1'b1, lcdwc_pkg::BYTE_W'($urandom), lcdwc_pkg::BYTE_W'($urandom),
                  lcdwc_pkg::BYTE_W'($urandom));
    random_phase();
    drain();
    apply_setting(1'($urandom), 8'd128, 8'd192, 8'd1);
    random_phase();
    drain();

    $display("Covered %0d items (%0d characters, %0d numbers) over %0d register settings.",
             items_sent, chars_sent, numbers_sent, settings_applied + 1);
    $display("Compared %0d strobe beats in %0d cycles.", strobes_checked, cycle_count);
    if (fail_count == 0) begin
      $display("char_lcd_write_controller_tb passed");
    end else begin
      $display("char_lcd_write_controller_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lcdwc_pkg.sv
design/lcdwc_ctrl.sv
design/lcdwc_dpath.sv
design/char_lcd_write_controller.sv
sim/lcd_strobe_checker.sv
sim/char_lcd_write_controller_tb.sv
